FILE: sv/ctat_pkg.sv
`timescale 1ns / 1ps
package ctat_pkg;

    localparam int KEY_SLOTS_DEF  = 16;
    localparam int TYPE_SLOTS_DEF = 32;
    localparam int COUNT_BITS_DEF = 24;
    localparam int MEASURES       = 3;

    localparam logic [7:0]  THRESH_RST     = 8'd5;
    localparam logic [3:0]  STD_MULT_RST   = 4'd3;
    localparam logic [3:0]  PEAK_MULT_RST  = 4'd2;
    localparam logic [15:0] MIN_SAMPLE_RST = 16'd3600;
    localparam logic [23:0] FLOOR_SRC_RST  = 24'd10;
    localparam logic [23:0] FLOOR_VOL_RST  = 24'd10000;
    localparam logic [23:0] FLOOR_FLOW_RST = 24'd100;

    typedef enum logic [2:0] {
        CFG_THRESH     = 3'd0,
        CFG_STD_MULT   = 3'd1,
        CFG_PEAK_MULT  = 3'd2,
        CFG_MIN_SAMPLE = 3'd3,
        CFG_FLOOR_SRC  = 3'd4,
        CFG_FLOOR_VOL  = 3'd5,
        CFG_FLOOR_FLOW = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  thresh;
        logic [3:0]  std_mult;
        logic [3:0]  peak_mult;
        logic [15:0] min_samples;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic clear;
    } lane_ctl_t;

    typedef struct packed {
        logic done;
        logic tag;
    } lane_sts_t;

    typedef enum logic [2:0] {
        T_SWEEP,
        T_IDLE,
        T_READ,
        T_RUN,
        T_RESULT
    } top_state_t;

    typedef enum logic [3:0] {
        L_IDLE,
        L_LOAD,
        L_VDIV,
        L_SQRT,
        L_ACC,
        L_TEST,
        L_MDIV,
        L_MEAN,
        L_MUL,
        L_SUM,
        L_WRITE
    } lane_state_t;

endpackage

FILE: sv/ctat_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module ctat_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {rem_reg, quo_reg[63]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/ctat_sqrt.sv
`timescale 1ns / 1ps
// Floor square root, one root bit per cycle.
module ctat_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;

    logic [35:0] cur;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    assign cur   = {rem_reg, rad_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= ge ? diff[33:0] : cur[33:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: sv/ctat_lane.sv
`timescale 1ns / 1ps
// One measure: CUSUM update, abnormal test and running statistics for all series.
module ctat_lane import ctat_pkg::*; #(
    parameter int DEPTH = KEY_SLOTS_DEF * TYPE_SLOTS_DEF,
    parameter int SW    = $clog2(KEY_SLOTS_DEF * TYPE_SLOTS_DEF),
    parameter int CB    = COUNT_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  lane_ctl_t     ctl,
    input  logic [SW-1:0] addr,
    input  logic [31:0]   n,
    input  logic [CB-1:0] data,
    input  cfg_t          cfg,
    input  logic [23:0]   floor_val,
    output lane_sts_t     sts
);

    localparam int XW  = CB + 8;
    localparam int MW  = (XW > 32) ? XW : 32;
    localparam int AW  = ((XW > 36) ? XW : 36) + 3;
    localparam int PW  = 2 * MW;
    localparam int FW  = (CB > 24) ? CB : 24;
    localparam int MCW = $clog2(MW + 1);
    localparam int WW  = CB + 32 + 64 + 16;

    lane_state_t state_reg, state_next;

    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] rd_q;

    logic [SW-1:0]  addr_reg;
    logic [31:0]    n_reg;
    logic [CB-1:0]  data_reg;
    logic [15:0]    cus_reg;
    logic [31:0]    sd_reg;
    logic           tag_reg;
    logic           dneg_reg;
    logic           eneg_reg;
    logic [MW-1:0]  a_reg;
    logic [MW-1:0]  b_reg;
    logic [31:0]    mean_new_reg;
    logic [63:0]    dsum_new_reg;
    logic [PW-1:0]  prod_reg;
    logic [MCW-1:0] mcnt_reg;

    logic [CB-1:0] peak_o;
    logic [31:0]   mean_o;
    logic [63:0]   dsum_o;
    logic [15:0]   cus_o;
    logic [XW-1:0] x;

    assign cus_o  = rd_q[15:0];
    assign dsum_o = rd_q[79:16];
    assign mean_o = rd_q[111:80];
    assign peak_o = rd_q[WW-1:112];
    assign x      = {data_reg, 8'b0};

    // shared divider: variance first, then the mean step
    logic        div_start, div_done;
    logic [63:0] div_dividend, div_q;
    logic [31:0] div_divisor;
    logic        sqrt_done;
    logic [31:0] sqrt_root;

    ctat_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    ctat_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == L_VDIV && div_done),
        .radicand (div_q),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // CUSUM step
    logic [35:0]   sdm;
    logic [AW-1:0] acc;
    logic [16:0]   cap17;
    logic [15:0]   cap16;
    logic [15:0]   cus_acc;

    assign sdm   = cfg.std_mult * sd_reg;
    assign acc   = AW'(cus_o) + AW'(x) - AW'(mean_o) - AW'(sdm);
    assign cap17 = {cfg.thresh, 9'b0};
    assign cap16 = cap17[16] ? 16'hFFFF : cap17[15:0];

    always_comb begin
        if (acc[AW-1] || acc == '0) begin
            cus_acc = '0;
        end else if (acc > AW'(cap16)) begin
            cus_acc = cap16;
        end else begin
            cus_acc = acc[15:0];
        end
    end

    // abnormal test
    logic [CB+3:0] pk_lim;
    logic          abn;
    logic          multi;

    assign pk_lim = cfg.peak_mult * peak_o;
    assign multi  = n_reg != 32'd1;
    assign abn    = (cus_reg > {cfg.thresh, 8'b0})
                 && (n_reg >= 32'(cfg.min_samples))
                 && ((CB+4)'(data_reg) > pk_lim)
                 && (FW'(data_reg) > FW'(floor_val));

    // mean and deviation terms
    logic [MW:0]   d_cur;
    logic [MW-1:0] a_cur;
    logic [MW-1:0] x_m;
    logic [31:0]   mean_first;
    logic [MW:0]   nm_full;
    logic [31:0]   nm32;
    logic [MW:0]   e_cur;

    assign d_cur      = (MW+1)'(x) - (MW+1)'(mean_o);
    assign a_cur      = d_cur[MW] ? MW'((MW+1)'(0) - d_cur) : d_cur[MW-1:0];
    assign x_m        = MW'(x);
    assign mean_first = (|(x_m >> 32)) ? 32'hFFFF_FFFF : x_m[31:0];
    assign nm_full    = dneg_reg ? (MW+1)'(mean_o) - (MW+1)'(div_q[MW-1:0])
                                 : (MW+1)'(mean_o) + (MW+1)'(div_q[MW-1:0]);
    assign nm32       = (|nm_full[MW:32]) ? 32'hFFFF_FFFF : nm_full[31:0];
    assign e_cur      = (MW+1)'(x) - (MW+1)'(mean_new_reg);

    // shift-add multiplier, one bit of b per cycle
    logic [MW:0]   mul_sum;
    logic [PW:0]   prod_ext;
    logic [63:0]   prod64;
    logic [64:0]   add65;
    logic          same_dir;
    logic [63:0]   ss_new;

    assign mul_sum  = (MW+1)'(prod_reg[PW-1:MW]) + (prod_reg[0] ? (MW+1)'(a_reg) : '0);
    assign prod_ext = {1'b0, prod_reg};
    assign prod64   = (|(prod_ext >> 64)) ? 64'hFFFF_FFFF_FFFF_FFFF : prod_ext[63:0];
    assign add65    = {1'b0, dsum_o} + {1'b0, prod64};
    assign same_dir = (dneg_reg == eneg_reg) || (a_reg == '0) || (b_reg == '0);

    always_comb begin
        if (same_dir) begin
            ss_new = add65[64] ? 64'hFFFF_FFFF_FFFF_FFFF : add65[63:0];
        end else if (dsum_o > prod64) begin
            ss_new = dsum_o - prod64;
        end else begin
            ss_new = '0;
        end
    end

    logic [CB-1:0] peak_new;
    assign peak_new = (!tag_reg && data_reg > peak_o) ? data_reg : peak_o;

    // divider operand select
    assign div_start    = (state_reg == L_LOAD && multi)
                       || (state_reg == L_TEST && !abn && multi);
    assign div_dividend = (state_reg == L_LOAD) ? dsum_o : 64'(a_cur);
    assign div_divisor  = (state_reg == L_LOAD) ? n_reg - 32'd1 : n_reg;

    // state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:  if (ctl.start) state_next = L_LOAD;
            L_LOAD:  state_next = multi ? L_VDIV : L_TEST;
            L_VDIV:  if (div_done) state_next = L_SQRT;
            L_SQRT:  if (sqrt_done) state_next = L_ACC;
            L_ACC:   state_next = L_TEST;
            L_TEST:  state_next = (abn || !multi) ? L_WRITE : L_MDIV;
            L_MDIV:  if (div_done) state_next = L_MEAN;
            L_MEAN:  state_next = L_MUL;
            L_MUL:   if (mcnt_reg == MCW'(MW - 1)) state_next = L_SUM;
            L_SUM:   state_next = L_WRITE;
            L_WRITE: state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            L_IDLE: begin
                if (ctl.start) begin
                    addr_reg <= addr;
                    n_reg    <= n;
                    data_reg <= data;
                end
            end
            L_LOAD: begin
                cus_reg <= cus_o;
            end
            L_SQRT: begin
                if (sqrt_done) begin
                    sd_reg <= sqrt_root;
                end
            end
            L_ACC: begin
                cus_reg <= cus_acc;
            end
            L_TEST: begin
                tag_reg  <= abn;
                dneg_reg <= d_cur[MW];
                a_reg    <= a_cur;
                if (abn) begin
                    mean_new_reg <= mean_o;
                    dsum_new_reg <= dsum_o;
                end else if (!multi) begin
                    mean_new_reg <= mean_first;
                    dsum_new_reg <= '0;
                end
            end
            L_MDIV: begin
                if (div_done) begin
                    mean_new_reg <= nm32;
                end
            end
            L_MEAN: begin
                eneg_reg <= e_cur[MW];
                b_reg    <= e_cur[MW] ? MW'((MW+1)'(0) - e_cur) : e_cur[MW-1:0];
                prod_reg <= {MW'(0),
                             e_cur[MW] ? MW'((MW+1)'(0) - e_cur) : e_cur[MW-1:0]};
                mcnt_reg <= '0;
            end
            L_MUL: begin
                prod_reg <= {mul_sum, prod_reg[MW-1:1]};
                mcnt_reg <= mcnt_reg + MCW'(1);
            end
            L_SUM: begin
                dsum_new_reg <= ss_new;
            end
            default: begin
            end
        endcase
    end

    // series store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            mem[addr] <= '0;
        end else if (state_reg == L_WRITE) begin
            mem[addr_reg] <= {peak_new, mean_new_reg, dsum_new_reg, cus_reg};
        end
        if (ctl.start) begin
            rd_q <= mem[addr];
        end
    end

    assign sts.done = state_reg == L_WRITE;
    assign sts.tag  = tag_reg;

endmodule

FILE: sv/cusum_traffic_anomaly_tagger.sv
`timescale 1ns / 1ps
// CUSUM traffic anomaly tagger.
// Input channel s_*: one transaction per sample or clear command, naming a series by
// key index and traffic type and carrying source, volume and flow counts.
// Output channel m_*: one transaction per input, a 3-bit tag (sources, volume, flows).
// Configuration: write cfg_wdata to register cfg_index while cfg_wr_en is high; only
// while the block is idle.
// After reset the block sweeps all KEY_SLOTS*TYPE_SLOTS series to zero with s_ready
// low; configuration writes are taken during the sweep.
// Clear commands and out-of-range series skip the lanes. A sample runs three measure
// lanes in parallel, each doing a variance division, a square root, a mean-step
// division and a multiply; a series' first sample skips all four, and an abnormal
// sample skips the mean-step division and the multiply.
// One item is in flight at a time. The result sits in an output register; a stalled
// receiver holds it there, and the next item may be accepted meanwhile, but its
// result waits until the register is free.
module cusum_traffic_anomaly_tagger import ctat_pkg::*; #(
    parameter int KEY_SLOTS  = KEY_SLOTS_DEF,
    parameter int TYPE_SLOTS = TYPE_SLOTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_index,
    input  logic [23:0]           cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [3:0]            s_key_index,
    input  logic [4:0]            s_traffic_type,
    input  logic [COUNT_BITS-1:0] s_src_count,
    input  logic [COUNT_BITS-1:0] s_volume,
    input  logic [COUNT_BITS-1:0] s_flow_count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_abnormal_tag
);

    localparam int SERIES = KEY_SLOTS * TYPE_SLOTS;
    localparam int SW     = $clog2(SERIES);

    top_state_t state_reg, state_next;

    cfg_t        cfg_reg;
    logic [23:0] floor_reg [MEASURES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.thresh      <= THRESH_RST;
            cfg_reg.std_mult    <= STD_MULT_RST;
            cfg_reg.peak_mult   <= PEAK_MULT_RST;
            cfg_reg.min_samples <= MIN_SAMPLE_RST;
            floor_reg[0]        <= FLOOR_SRC_RST;
            floor_reg[1]        <= FLOOR_VOL_RST;
            floor_reg[2]        <= FLOOR_FLOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_THRESH:     cfg_reg.thresh      <= cfg_wdata[7:0];
                CFG_STD_MULT:   cfg_reg.std_mult    <= cfg_wdata[3:0];
                CFG_PEAK_MULT:  cfg_reg.peak_mult   <= cfg_wdata[3:0];
                CFG_MIN_SAMPLE: cfg_reg.min_samples <= cfg_wdata[15:0];
                CFG_FLOOR_SRC:  floor_reg[0]        <= cfg_wdata;
                CFG_FLOOR_VOL:  floor_reg[1]        <= cfg_wdata;
                CFG_FLOOR_FLOW: floor_reg[2]        <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input decode
    logic          accept;
    logic          in_range;
    logic [SW-1:0] s_calc;

    assign accept   = s_valid && s_ready;
    assign in_range = (32'(s_key_index) < KEY_SLOTS) && (32'(s_traffic_type) < TYPE_SLOTS);
    assign s_calc   = SW'(32'(s_key_index) * TYPE_SLOTS + 32'(s_traffic_type));

    logic [SW-1:0]         s_reg;
    logic [COUNT_BITS-1:0] data_reg [MEASURES];
    logic [SW-1:0]         sweep_cnt_reg;
    logic [2:0]            done_mask_reg;
    logic [2:0]            tag_acc_reg;
    logic                  m_valid_reg;
    logic [2:0]            m_tag_reg;

    // per-series sample count
    logic [31:0] cnt_mem [SERIES];
    logic [31:0] cnt_q;
    logic [31:0] n_cur;

    assign n_cur = (cnt_q == 32'hFFFF_FFFF) ? cnt_q : cnt_q + 32'd1;

    always_ff @(posedge aclk) begin
        if (state_reg == T_SWEEP) begin
            cnt_mem[sweep_cnt_reg] <= '0;
        end else if (accept && in_range && s_command) begin
            cnt_mem[s_calc] <= '0;
        end else if (state_reg == T_READ) begin
            cnt_mem[s_reg] <= n_cur;
        end
        if (accept) begin
            cnt_q <= cnt_mem[s_calc];
        end
    end

    // lanes
    lane_ctl_t     lane_ctl;
    logic [SW-1:0] lane_addr;
    lane_sts_t     lane_sts [MEASURES];
    logic [2:0]    lane_done;
    logic [2:0]    lane_tag;

    assign lane_ctl.start = state_reg == T_READ;
    assign lane_ctl.clear = (state_reg == T_SWEEP) || (accept && in_range && s_command);
    assign lane_addr      = (state_reg == T_SWEEP) ? sweep_cnt_reg
                          : (state_reg == T_READ)  ? s_reg : s_calc;

    for (genvar i = 0; i < MEASURES; i++) begin : g_lane
        ctat_lane #(
            .DEPTH (SERIES),
            .SW    (SW),
            .CB    (COUNT_BITS)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (lane_ctl),
            .addr      (lane_addr),
            .n         (n_cur),
            .data      (data_reg[i]),
            .cfg       (cfg_reg),
            .floor_val (floor_reg[i]),
            .sts       (lane_sts[i])
        );
        assign lane_done[i] = lane_sts[i].done;
        assign lane_tag[i]  = lane_sts[i].tag;
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            T_SWEEP: begin
                if (sweep_cnt_reg == SW'(SERIES - 1)) state_next = T_IDLE;
            end
            T_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    state_next = (in_range && !s_command) ? T_READ : T_RESULT;
                end
            end
            T_READ:   state_next = T_RUN;
            T_RUN: begin
                if ((done_mask_reg | lane_done) == 3'b111) state_next = T_RESULT;
            end
            T_RESULT: begin
                if (out_free) state_next = T_IDLE;
            end
            default:  state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_cnt_reg <= '0;
            done_mask_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (state_reg == T_SWEEP) begin
                sweep_cnt_reg <= sweep_cnt_reg + SW'(1);
            end
            if (state_reg == T_READ) begin
                done_mask_reg <= '0;
            end else if (state_reg == T_RUN) begin
                done_mask_reg <= done_mask_reg | lane_done;
            end
            if (state_reg == T_RESULT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s_reg       <= s_calc;
            data_reg[0] <= s_src_count;
            data_reg[1] <= s_volume;
            data_reg[2] <= s_flow_count;
            tag_acc_reg <= '0;
        end else if (state_reg == T_RUN) begin
            for (int i = 0; i < MEASURES; i++) begin
                if (lane_done[i]) begin
                    tag_acc_reg[i] <= lane_tag[i];
                end
            end
        end
        if (state_reg == T_RESULT && out_free) begin
            m_tag_reg <= tag_acc_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_abnormal_tag = m_tag_reg;

    // checks
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted while one is in flight");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == T_RESULT))
        else $error("result raised outside result state");

    a_lane_done_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != T_RUN) |-> (lane_done == 3'b000))
        else $error("lane finished while no sample was running");

endmodule
